[hdl/fiws_pkg.sv]
package fiws_pkg;

	// Field widths of the frame and result beats.
	localparam int unsigned ID_W = 32;
	localparam int unsigned IVL_W = 16;
	localparam int unsigned BYTES_W = 24;
	localparam int unsigned KIB_W = 14;
	localparam int unsigned KIB_SHIFT = 10;

	// Default window length in frames.
	localparam int unsigned WINDOW_DEF = 256;

	typedef struct packed {
		logic [ID_W-1:0]    frame_id;
		logic [IVL_W-1:0]   interval;
		logic [BYTES_W-1:0] frame_bytes;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    frame_id_out;
		logic [IVL_W-1:0]   mean_interval;
		logic [IVL_W-1:0]   interval_deviation;
		logic [BYTES_W-1:0] mean_bytes;
		logic [IVL_W-1:0]   peak_interval;
		logic [IVL_W-1:0]   least_interval;
		logic [BYTES_W-1:0] peak_bytes;
		logic [BYTES_W-1:0] least_bytes;
		logic [KIB_W-1:0]   size_kib;
	} out_item_t;

	// Sequencer states of the top level.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV,
		ST_WAIT,
		ST_FINISH
	} state_t;

	// Controls from the sequencer to the window store.
	typedef struct packed {
		logic rd_en;
		logic upd_en;
	} win_ctrl_t;

endpackage

[hdl/fiws_div.sv]
// Restoring divider: one quotient bit per cycle, DVD_W quotient bits per division.
module fiws_div #(
	parameter int unsigned DVD_W = 32,
	parameter int unsigned DVS_W = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             busy,
	output logic [DVD_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;

	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             fits;

	// One step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		shifted = {rem_q, quo_q[DVD_W-1]};
		diff = shifted - {1'b0, dvs_q};
		fits = (shifted >= {1'b0, dvs_q});
	end

	// Control state of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Partial remainder and quotient, shifted together.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

endmodule

[hdl/fiws_window.sv]
// Ring stores of the last WINDOW intervals and sizes, with running sums.
module fiws_window #(
	parameter int unsigned WINDOW = fiws_pkg::WINDOW_DEF,
	localparam int unsigned SLOT_W = $clog2(WINDOW),
	localparam int unsigned FILL_W = $clog2(WINDOW + 1),
	localparam int unsigned ISUM_W = fiws_pkg::IVL_W + SLOT_W,
	localparam int unsigned BSUM_W = fiws_pkg::BYTES_W + SLOT_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fiws_pkg::win_ctrl_t          ctrl,
	input  logic [fiws_pkg::IVL_W-1:0]   ivl,
	input  logic [fiws_pkg::BYTES_W-1:0] bytes,
	output logic [ISUM_W-1:0]            isum,
	output logic [BSUM_W-1:0]            bsum,
	output logic [FILL_W-1:0]            fill
);

	logic [fiws_pkg::IVL_W-1:0]   ivl_ring [WINDOW];
	logic [fiws_pkg::BYTES_W-1:0] bytes_ring [WINDOW];

	logic [fiws_pkg::IVL_W-1:0]   rd_ivl_q;
	logic [fiws_pkg::BYTES_W-1:0] rd_bytes_q;

	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [ISUM_W-1:0] isum_q;
	logic [BSUM_W-1:0] bsum_q;

	logic              full;
	logic [ISUM_W-1:0] isum_drop;
	logic [BSUM_W-1:0] bsum_drop;

	// The oldest entry is read in the cycle before the update that replaces it.
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_ivl_q <= ivl_ring[slot_q];
			rd_bytes_q <= bytes_ring[slot_q];
		end
		if (ctrl.upd_en) begin
			ivl_ring[slot_q] <= ivl;
			bytes_ring[slot_q] <= bytes;
		end
	end

	// Once the window is full, the entry being overwritten leaves the sums.
	always_comb begin
		full = (fill_q == FILL_W'(WINDOW));
		isum_drop = full ? ISUM_W'(rd_ivl_q) : '0;
		bsum_drop = full ? BSUM_W'(rd_bytes_q) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
			isum_q <= '0;
			bsum_q <= '0;
		end else if (ctrl.upd_en) begin
			isum_q <= isum_q - isum_drop + ISUM_W'(ivl);
			bsum_q <= bsum_q - bsum_drop + BSUM_W'(bytes);
			slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			if (!full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign isum = isum_q;
	assign bsum = bsum_q;
	assign fill = fill_q;

endmodule

[hdl/frame_interval_window_stats_core.sv]
// Channel   Signals                              Beat
// item      item_valid, item_ready, item         one frame: id, interval, size
// result    result_valid, result_ready, result   statistics of that frame
//
// A frame passes the sequencer states READ, UPDATE, DIV, WAIT and FINISH; WAIT lasts until
// both bit-serial mean dividers are done, and the one for the sizes, the wider, sets it.
// result_valid rises as FINISH loads the output register. Frames are handled one at a time;
// the next frame is taken while a result still waits in the output register. Reset
// empties the window and the extremes; the ring memories need no clearing. A stalled
// result holds the sequencer in its last state until the output register is free.
module frame_interval_window_stats_core #(
	parameter int unsigned WINDOW = fiws_pkg::WINDOW_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  fiws_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output fiws_pkg::out_item_t result
);

	localparam int unsigned SLOT_W = $clog2(WINDOW);
	localparam int unsigned FILL_W = $clog2(WINDOW + 1);
	localparam int unsigned ISUM_W = fiws_pkg::IVL_W + SLOT_W;
	localparam int unsigned BSUM_W = fiws_pkg::BYTES_W + SLOT_W;

	fiws_pkg::state_t    state_q;
	fiws_pkg::state_t    state_nxt;
	fiws_pkg::in_item_t  item_q;
	fiws_pkg::out_item_t result_q;
	logic                result_valid_q;
	fiws_pkg::win_ctrl_t win_ctrl;

	logic                         div_start;
	logic                         res_load;
	logic                         ibusy;
	logic                         bbusy;
	logic [ISUM_W-1:0]            isum;
	logic [BSUM_W-1:0]            bsum;
	logic [FILL_W-1:0]            fill;
	logic [ISUM_W-1:0]            iquo;
	logic [BSUM_W-1:0]            bquo;

	logic [fiws_pkg::IVL_W-1:0]   peak_ivl_q;
	logic [fiws_pkg::IVL_W-1:0]   least_ivl_q;
	logic [fiws_pkg::BYTES_W-1:0] peak_bytes_q;
	logic [fiws_pkg::BYTES_W-1:0] least_bytes_q;

	logic [fiws_pkg::IVL_W-1:0]   mean_ivl;
	logic [fiws_pkg::IVL_W-1:0]   deviation;
	logic                         out_free;

	fiws_window #(
		.WINDOW(WINDOW)
	) u_window (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (win_ctrl),
		.ivl   (item_q.interval),
		.bytes (item_q.frame_bytes),
		.isum  (isum),
		.bsum  (bsum),
		.fill  (fill)
	);

	fiws_div #(
		.DVD_W(ISUM_W),
		.DVS_W(FILL_W)
	) u_div_ivl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(isum),
		.divisor (fill),
		.busy    (ibusy),
		.quotient(iquo)
	);

	fiws_div #(
		.DVD_W(BSUM_W),
		.DVS_W(FILL_W)
	) u_div_bytes (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(bsum),
		.divisor (fill),
		.busy    (bbusy),
		.quotient(bquo)
	);

	assign out_free = !result_valid_q || result_ready;

	// Next state of the sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fiws_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_nxt = fiws_pkg::ST_READ;
				end
			end
			fiws_pkg::ST_READ:   state_nxt = fiws_pkg::ST_UPDATE;
			fiws_pkg::ST_UPDATE: state_nxt = fiws_pkg::ST_DIV;
			fiws_pkg::ST_DIV:    state_nxt = fiws_pkg::ST_WAIT;
			fiws_pkg::ST_WAIT: begin
				if (!ibusy && !bbusy) begin
					state_nxt = fiws_pkg::ST_FINISH;
				end
			end
			fiws_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nxt = fiws_pkg::ST_IDLE;
				end
			end
			default: state_nxt = fiws_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		item_ready = 1'b0;
		win_ctrl = '0;
		div_start = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			fiws_pkg::ST_IDLE:   item_ready = 1'b1;
			fiws_pkg::ST_READ:   win_ctrl.rd_en = 1'b1;
			fiws_pkg::ST_UPDATE: win_ctrl.upd_en = 1'b1;
			fiws_pkg::ST_DIV:    div_start = 1'b1;
			fiws_pkg::ST_WAIT:   ;
			fiws_pkg::ST_FINISH: res_load = out_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fiws_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Frame under work.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

	// All-time extremes; a minimum of zero is empty and takes the next value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_ivl_q <= '0;
			least_ivl_q <= '0;
			peak_bytes_q <= '0;
			least_bytes_q <= '0;
		end else if (win_ctrl.upd_en) begin
			if (item_q.interval > peak_ivl_q) begin
				peak_ivl_q <= item_q.interval;
			end
			if (least_ivl_q == '0 || least_ivl_q > item_q.interval) begin
				least_ivl_q <= item_q.interval;
			end
			if (item_q.frame_bytes > peak_bytes_q) begin
				peak_bytes_q <= item_q.frame_bytes;
			end
			if (least_bytes_q == '0 || least_bytes_q > item_q.frame_bytes) begin
				least_bytes_q <= item_q.frame_bytes;
			end
		end
	end

	// The means never exceed the largest value in the window.
	always_comb begin
		mean_ivl = iquo[fiws_pkg::IVL_W-1:0];
		deviation = (item_q.interval >= mean_ivl) ? item_q.interval - mean_ivl
		                                           : mean_ivl - item_q.interval;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q.frame_id_out <= item_q.frame_id;
			result_q.mean_interval <= mean_ivl;
			result_q.interval_deviation <= deviation;
			result_q.mean_bytes <= bquo[fiws_pkg::BYTES_W-1:0];
			result_q.peak_interval <= peak_ivl_q;
			result_q.least_interval <= least_ivl_q;
			result_q.peak_bytes <= peak_bytes_q;
			result_q.least_bytes <= least_bytes_q;
			result_q.size_kib <= item_q.frame_bytes[fiws_pkg::BYTES_W-1:fiws_pkg::KIB_SHIFT];
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

`ifndef ASSERT_OFF
	// A frame is accepted only when no other frame is in work.
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready && state_q == fiws_pkg::ST_READ)
		else $error("frame accepted while another is in work");

	// Results are formed only from finished divisions.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !ibusy && !bbusy)
		else $error("result loaded while a divider is busy");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !res_load)
		else $error("output register overwritten while stalled");

	// The window never holds more than WINDOW frames.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FILL_W'(WINDOW))
		else $error("fill count beyond window length");

	// Both extremes track the same values, so the least never passes the peak.
	a_extreme_order: assert property (@(posedge clk) disable iff (!arst_n)
		least_ivl_q <= peak_ivl_q && least_bytes_q <= peak_bytes_q)
		else $error("least value above peak value");
`endif

endmodule
